// ===== design/assert_macros.svh =====
// Concurrent check macros, compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define RPT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: check failed");

`define RPT_ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("%m: implication failed");

`define RPT_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("%m: next-cycle check failed");

`else

`define RPT_ASSERT(label, clk, rst_n, prop)
`define RPT_ASSERT_IMPL(label, clk, rst_n, pre, post)
`define RPT_ASSERT_NEXT(label, clk, rst_n, pre, post)

`endif

`endif

// ===== design/rpt_pkg.sv =====
package rpt_pkg;

    localparam int RINGS   = 64;
    localparam int RING_AW = (RINGS > 1) ? $clog2(RINGS) : 1;

    localparam int COORD_W = 24;
    localparam int AZ_W    = 15;
    localparam int TIME_W  = 18;
    localparam int CFG_W   = 16;

    localparam logic [TIME_W-1:0] TIME_MAX   = '1;
    localparam logic [19:0]       TURN_UNITS = 20'd23040;

    // CORDIC angle accumulator, 1/1024 degree
    localparam int ZW = 20;
    localparam logic signed [ZW-1:0] HALF_TURN_Z = 20'sd184320;
    localparam int CORDIC_STEPS = 16;

    localparam logic [16:0] ATAN_TAB [CORDIC_STEPS] = '{
        17'd46080, 17'd27203, 17'd14373, 17'd7296, 17'd3662, 17'd1833, 17'd917, 17'd458,
        17'd229,   17'd115,   17'd57,    17'd29,   17'd14,   17'd7,    17'd4,   17'd2
    };

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [AZ_W-1:0]    az_t;
    typedef logic [TIME_W-1:0]         time_t;

    typedef enum logic [1:0] {
        REG_DECIMATION = 2'd0,
        REG_TS_PRESENT = 2'd1,
        REG_TIME_GAIN  = 2'd2,
        REG_MS_PER_DEG = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TMUL,
        S_TSCALE,
        S_CORDIC,
        S_RING,
        S_DMUL,
        S_TURN,
        S_ADJ,
        S_OUT
    } state_t;

    typedef struct packed {
        az_t   first_az;
        time_t last_time;
    } ring_entry_t;

    typedef struct packed {
        logic               en;
        logic [RING_AW-1:0] addr;
        ring_entry_t        data;
    } ring_wr_t;

endpackage

// ===== design/rpt_cordic.sv =====
module rpt_cordic (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  rpt_pkg::coord_t x_in,
    input  rpt_pkg::coord_t y_in,
    output logic            done,
    output rpt_pkg::az_t    az
);
    import rpt_pkg::*;

    localparam int XW = COORD_W + 3;

    logic                 busy_reg;
    logic [3:0]           iter_reg;
    logic                 done_reg;
    logic                 origin_reg;
    logic signed [XW-1:0] x_reg, x_next;
    logic signed [XW-1:0] y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;

    logic signed [XW-1:0] x_ext, y_ext, xs, ys;
    logic signed [ZW-1:0] step_angle, z_rnd;
    logic                 last_step;

    assign x_ext      = XW'(x_in);
    assign y_ext      = XW'(y_in);
    assign xs         = x_reg >>> iter_reg;
    assign ys         = y_reg >>> iter_reg;
    assign step_angle = $signed({{(ZW-17){1'b0}}, ATAN_TAB[iter_reg]});
    assign last_step  = (iter_reg == 4'(CORDIC_STEPS - 1));

    always_comb
    begin
        if (start)
        begin
            // left half plane: flip by 180 degrees first
            if (x_in < 0)
            begin
                x_next = -x_ext;
                y_next = -y_ext;
                z_next = (y_in >= 0) ? HALF_TURN_Z : -HALF_TURN_Z;
            end
            else
            begin
                x_next = x_ext;
                y_next = y_ext;
                z_next = '0;
            end
        end
        else if (y_reg > 0)
        begin
            x_next = x_reg + ys;
            y_next = y_reg - xs;
            z_next = z_reg + step_angle;
        end
        else
        begin
            x_next = x_reg - ys;
            y_next = y_reg + xs;
            z_next = z_reg - step_angle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            iter_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && last_step;
            if (start)
            begin
                busy_reg <= 1'b1;
                iter_reg <= '0;
            end
            else if (busy_reg)
            begin
                iter_reg <= iter_reg + 4'd1;
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start || busy_reg)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
        if (start)
        begin
            origin_reg <= (x_in == 0) && (y_in == 0);
        end
    end

    // round 1/1024 deg to 1/64 deg, floor((z + 8) / 16)
    assign z_rnd = z_reg + ZW'(8);
    assign az    = origin_reg ? '0 : z_rnd[AZ_W+3:4];
    assign done  = done_reg;

endmodule

// ===== design/rpt_ring_mem.sv =====
module rpt_ring_mem (
    input  logic                        clk,
    input  rpt_pkg::ring_wr_t           wr,
    input  logic [rpt_pkg::RING_AW-1:0] rd_addr,
    output rpt_pkg::ring_entry_t        rd_data
);
    import rpt_pkg::*;

    ring_entry_t mem [RINGS];
    ring_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/ring_point_time_from_yaw_unit.sv =====
// Channel   Dir  Handshake           Payload
// input     in   in_valid/in_stall   frame_start, x/y/z_coord, ring, point_time, coords_invalid
// result    out  out_valid/out_stall out_x, out_y, out_z, out_time
// config    in   cfg_write_en        cfg_index, cfg_data (no read-back)
//
// Sensor-time points pass S_TMUL and S_TSCALE, then load the result register in S_OUT.
// Azimuth points run the 16-step CORDIC loop, read the ring entry in S_RING, then make one
// pass each through the shared 20x16 multiplier for angle and turn before S_ADJ and S_OUT.
// Dropped points never stall the input; the first point of a ring only writes its reference.
// Input stalls while a point is in work; a held result stalls only a next result at S_OUT.
// Reset clears ring marks and decimation phase; ring memory needs no clearing pass.
`include "assert_macros.svh"

module ring_point_time_from_yaw_unit (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write_en,
    input  logic [1:0]               cfg_index,
    input  logic [rpt_pkg::CFG_W-1:0] cfg_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     frame_start,
    input  rpt_pkg::coord_t          x_coord,
    input  rpt_pkg::coord_t          y_coord,
    input  rpt_pkg::coord_t          z_coord,
    input  logic [5:0]               ring,
    input  logic [19:0]              point_time,
    input  logic                     coords_invalid,
    output logic                     out_valid,
    input  logic                     out_stall,
    output rpt_pkg::coord_t          out_x,
    output rpt_pkg::coord_t          out_y,
    output rpt_pkg::coord_t          out_z,
    output rpt_pkg::time_t           out_time
);
    import rpt_pkg::*;

    // configuration
    logic [6:0]  decim_reg;
    logic        ts_reg;
    logic [15:0] gain_reg;
    logic [15:0] mpd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decim_reg <= 7'd1;
            ts_reg    <= 1'b0;
            gain_reg  <= 16'd262;
            mpd_reg   <= 16'd18154;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_DECIMATION: decim_reg <= cfg_data[6:0];
                REG_TS_PRESENT: ts_reg    <= cfg_data[0];
                REG_TIME_GAIN:  gain_reg  <= cfg_data;
                REG_MS_PER_DEG: mpd_reg   <= cfg_data;
            endcase
        end
    end

    state_t state_reg, state_next;

    logic       in_accept;
    logic [5:0] phase_reg, phase_eff;
    logic [6:0] interval, phase_inc;
    logic       keep;
    logic [6:0] ring_ext;
    logic       ring_ok;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        if (decim_reg == 7'd0)
        begin
            interval = 7'd1;
        end
        else if (decim_reg > 7'd64)
        begin
            interval = 7'd64;
        end
        else
        begin
            interval = decim_reg;
        end
    end

    assign phase_eff = frame_start ? '0 : phase_reg;
    assign phase_inc = {1'b0, phase_eff} + 7'd1;
    assign keep      = (phase_eff == '0) && !coords_invalid;
    assign ring_ext  = {1'b0, ring};
    assign ring_ok   = (ring_ext < 7'(RINGS));

    // captured request
    coord_t             x_reg, y_reg, zc_reg;
    logic [19:0]        pt_reg;
    logic [RING_AW-1:0] ring_addr_reg;

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            x_reg         <= x_coord;
            y_reg         <= y_coord;
            zc_reg        <= z_coord;
            pt_reg        <= point_time;
            ring_addr_reg <= ring_ext[RING_AW-1:0];
        end
    end

    // CORDIC and ring memory
    logic        cordic_start, cordic_done;
    az_t         az;
    ring_wr_t    ring_wr;
    ring_entry_t ring_rd;
    logic [RINGS-1:0] ring_seen_reg;
    logic        seen;

    rpt_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .x_in  (x_coord),
        .y_in  (y_coord),
        .done  (cordic_done),
        .az    (az)
    );

    rpt_ring_mem u_ring_mem (
        .clk     (clk),
        .wr      (ring_wr),
        .rd_addr (ring_addr_reg),
        .rd_data (ring_rd)
    );

    assign seen = ring_seen_reg[ring_addr_reg];

    // shared multiplier and time arithmetic
    logic [19:0]          mul_a;
    logic [15:0]          mul_b;
    logic [35:0]          prod_reg;
    logic [36:0]          ts_sum;
    logic [28:0]          ts_scaled;
    logic [35:0]          rnd12;
    logic [18:0]          prod_q12, tbase_reg;
    logic [19:0]          t_adj;
    logic [15:0]          az_diff;
    logic signed [16:0]   d_raw;
    logic [14:0]          d_reg;
    time_t                time_reg, t_sat, ts_sat;
    logic                 load_out, out_valid_reg;

    assign ts_sum    = {1'b0, prod_reg} + 37'd128;
    assign ts_scaled = ts_sum[36:8];
    assign ts_sat    = (|ts_scaled[28:TIME_W]) ? TIME_MAX : ts_scaled[TIME_W-1:0];

    // products on the azimuth path stay below 2^31
    assign rnd12    = prod_reg + 36'd2048;
    assign prod_q12 = rnd12[30:12];

    assign az_diff = {ring_rd.first_az[AZ_W-1], ring_rd.first_az} - {az[AZ_W-1], az};
    assign d_raw   = $signed({az_diff[15], az_diff})
                   + ((az > ring_rd.first_az) ? $signed(17'(TURN_UNITS)) : 17'sd0);

    // add one turn when the ring's time went backward
    assign t_adj = (tbase_reg < {1'b0, ring_rd.last_time})
                 ? ({1'b0, tbase_reg} + {1'b0, prod_q12}) : {1'b0, tbase_reg};
    assign t_sat = (|t_adj[19:TIME_W]) ? TIME_MAX : t_adj[TIME_W-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept && keep)
                begin
                    if (ts_reg)
                    begin
                        state_next = S_TMUL;
                    end
                    else if (ring_ok)
                    begin
                        state_next = S_CORDIC;
                    end
                end
            end
            S_TMUL:   state_next = S_TSCALE;
            S_TSCALE: state_next = S_OUT;
            S_CORDIC:
            begin
                if (cordic_done)
                begin
                    state_next = S_RING;
                end
            end
            S_RING:   state_next = seen ? S_DMUL : S_IDLE;
            S_DMUL:   state_next = S_TURN;
            S_TURN:   state_next = S_ADJ;
            S_ADJ:    state_next = S_OUT;
            S_OUT:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // datapath controls
    always_comb
    begin
        cordic_start = 1'b0;
        mul_a        = pt_reg;
        mul_b        = gain_reg;
        ring_wr      = '{en: 1'b0, addr: ring_addr_reg, data: '{first_az: az, last_time: '0}};
        load_out     = 1'b0;
        unique case (state_reg)
            S_IDLE:   cordic_start = in_accept && keep && !ts_reg && ring_ok;
            S_TMUL:   mul_a = pt_reg;
            S_RING:   ring_wr.en = !seen;
            S_DMUL:
            begin
                mul_a = {5'd0, d_reg};
                mul_b = mpd_reg;
            end
            S_TURN:
            begin
                mul_a = TURN_UNITS;
                mul_b = mpd_reg;
            end
            S_ADJ:
            begin
                ring_wr.en   = 1'b1;
                ring_wr.data = '{first_az: ring_rd.first_az, last_time: t_sat};
            end
            S_OUT:    load_out = !out_valid_reg || !out_stall;
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= '0;
            ring_seen_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_accept)
            begin
                phase_reg <= (phase_inc >= interval) ? '0 : phase_inc[5:0];
                if (frame_start)
                begin
                    ring_seen_reg <= '0;
                end
            end
            if (state_reg == S_RING && !seen)
            begin
                ring_seen_reg[ring_addr_reg] <= 1'b1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_TMUL || state_reg == S_DMUL || state_reg == S_TURN)
        begin
            prod_reg <= mul_a * mul_b;
        end
        if (state_reg == S_RING)
        begin
            d_reg <= d_raw[16] ? '0 : d_raw[14:0];
        end
        if (state_reg == S_TURN)
        begin
            tbase_reg <= prod_q12;
        end
        if (state_reg == S_TSCALE)
        begin
            time_reg <= ts_sat;
        end
        else if (state_reg == S_ADJ)
        begin
            time_reg <= t_sat;
        end
        if (load_out)
        begin
            out_x    <= x_reg;
            out_y    <= y_reg;
            out_z    <= zc_reg;
            out_time <= time_reg;
        end
    end

    assign out_valid = out_valid_reg;

    `RPT_ASSERT_IMPL(a_done_in_cordic, clk, rst_n, cordic_done, state_reg == S_CORDIC)
    `RPT_ASSERT_IMPL(a_out_from_seq, clk, rst_n, $rose(out_valid_reg), $past(state_reg == S_OUT))
    `RPT_ASSERT_NEXT(a_ring_marked, clk, rst_n, state_reg == S_RING,
                     ring_seen_reg[$past(ring_addr_reg)])
    `RPT_ASSERT_IMPL(a_wr_states, clk, rst_n, ring_wr.en,
                     state_reg == S_RING || state_reg == S_ADJ)

endmodule

// ===== dv/ring_point_time_from_yaw_unit_test.sv =====
module ring_point_time_from_yaw_unit_test;
    import rpt_pkg::*;

    localparam int CYCLE_LIMIT     = 600000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int MAX_SHOWN       = 10;
    localparam longint FULL_TURN_64    = 23040;
    localparam longint TIME_CEIL       = 262143;

    typedef struct {
        bit          fs;
        coord_t      x;
        coord_t      y;
        coord_t      z;
        logic [5:0]  ring;
        logic [19:0] pt;
        bit          inv;
    } point_req_t;

    typedef struct {
        coord_t x;
        coord_t y;
        coord_t z;
        time_t  t;
    } point_result_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_write_en;
    logic [1:0]          cfg_index;
    logic [CFG_W-1:0]    cfg_data;
    logic                in_valid;
    logic                in_stall;
    logic                frame_start;
    coord_t              x_coord;
    coord_t              y_coord;
    coord_t              z_coord;
    logic [5:0]          ring;
    logic [19:0]         point_time;
    logic                coords_invalid;
    logic                out_valid;
    logic                out_stall;
    coord_t              out_x;
    coord_t              out_y;
    coord_t              out_z;
    time_t               out_time;

    // predictor copy of the registers and ring memory
    int      cfg_interval;
    bit      cfg_use_sensor_time;
    longint  cfg_gain;
    longint  cfg_ms_per_deg;
    bit      ring_marked [RINGS];
    int      ring_first_az [RINGS];
    longint  ring_last_time [RINGS];
    int      point_phase;

    point_result_t pending_points [$];
    int      fault_count = 0;
    int      cycle_count = 0;
    int      hold_left = 0;
    logic    rx_hold;
    int      rx_wait;
    bit      idling = 1'b1;

    // CORDIC step angles, 1/1024 degree
    longint  arctan_step [16] = '{46080, 27203, 14373, 7296, 3662, 1833, 917, 458,
                                  229, 115, 57, 29, 14, 7, 4, 2};
    int      sweep_interval [10] = '{0, 1, 64, 127, 2, 3, 1, 100, 5, 1};
    bit      sweep_sensor [10]   = '{1, 0, 1, 1, 0, 1, 0, 1, 0, 0};

    ring_point_time_from_yaw_unit u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .frame_start    (frame_start),
        .x_coord        (x_coord),
        .y_coord        (y_coord),
        .z_coord        (z_coord),
        .ring           (ring),
        .point_time     (point_time),
        .coords_invalid (coords_invalid),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_x          (out_x),
        .out_y          (out_y),
        .out_z          (out_z),
        .out_time       (out_time)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("ring_point_time_from_yaw_unit_test: done, errors");
        $finish;
    end

    // long receiver hold-off, armed by a test task
    initial
    begin
        rx_hold = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                rx_hold   <= 1'b1;
            end
            else
                rx_hold <= 1'b0;
        end
    end

    function automatic int azimuth_64th(coord_t xc, coord_t yc);
        longint xv, yv, zv, xs, ys;
        xv = xc;
        yv = yc;
        zv = 0;
        if (xv == 0 && yv == 0)
            return 0;
        if (xv < 0)
        begin
            zv = (yv >= 0) ? 184320 : -184320;
            xv = -xv;
            yv = -yv;
        end
        for (int i = 0; i < 16; i++)
        begin
            xs = xv >>> i;
            ys = yv >>> i;
            if (yv > 0)
            begin
                xv = xv + ys;
                yv = yv - xs;
                zv = zv + arctan_step[i];
            end
            else
            begin
                xv = xv - ys;
                yv = yv + xs;
                zv = zv - arctan_step[i];
            end
        end
        return int'((zv + 8) >>> 4);
    endfunction

    function automatic longint degrees_to_time(longint d);
        if (d < 0)
            d = 0;
        return (d * cfg_ms_per_deg + 2048) >>> 12;
    endfunction

    task automatic predict_point_time(point_req_t p);
        int            interval;
        bit            keep;
        longint        t;
        longint        d;
        int            az;
        point_result_t res;
        interval = cfg_interval;
        if (interval == 0)
            interval = 1;
        if (interval > 64)
            interval = 64;
        if (p.fs)
        begin
            foreach (ring_marked[i])
                ring_marked[i] = 1'b0;
            point_phase = 0;
        end
        keep = (point_phase == 0);
        point_phase = (point_phase + 1 >= interval) ? 0 : point_phase + 1;
        if (!keep || p.inv)
            return;
        if (cfg_use_sensor_time)
            t = (longint'(p.pt) * cfg_gain + 128) >>> 8;
        else
        begin
            az = azimuth_64th(p.x, p.y);
            // first point of a ring only sets the reference azimuth
            if (!ring_marked[p.ring])
            begin
                ring_marked[p.ring]    = 1'b1;
                ring_first_az[p.ring]  = az;
                ring_last_time[p.ring] = 0;
                return;
            end
            d = longint'(ring_first_az[p.ring]) - az;
            if (az > ring_first_az[p.ring])
                d += FULL_TURN_64;
            t = degrees_to_time(d);
            if (t < ring_last_time[p.ring])
                t += degrees_to_time(FULL_TURN_64);
        end
        if (t > TIME_CEIL)
            t = TIME_CEIL;
        if (!cfg_use_sensor_time)
            ring_last_time[p.ring] = t;
        res.x = p.x;
        res.y = p.y;
        res.z = p.z;
        res.t = time_t'(t);
        pending_points.insert(pending_points.size(), res);
    endtask

    task automatic check_point_result();
        point_result_t want;
        if (pending_points.size() == 0)
        begin
            fault_count++;
            if (fault_count <= MAX_SHOWN)
                $display("unexpected result: x=%0d y=%0d z=%0d t=%0d",
                         out_x, out_y, out_z, out_time);
        end
        else
        begin
            want = pending_points.pop_front();
            if (want.x !== out_x || want.y !== out_y || want.z !== out_z
                || want.t !== out_time)
            begin
                fault_count++;
                if (fault_count <= MAX_SHOWN)
                    $display("mismatch: exp x=%0d y=%0d z=%0d t=%0d got x=%0d y=%0d z=%0d t=%0d",
                             want.x, want.y, want.z, want.t,
                             out_x, out_y, out_z, out_time);
            end
        end
    endtask

    // result side: random hold per result, plus the long hold-off
    initial
    begin
        out_stall = 1'b0;
        rx_wait   = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                check_point_result();
                rx_wait = idling ? $urandom_range(0, 5) : 0;
            end
            else if (rst_n && out_valid && rx_wait > 0)
                rx_wait--;
            out_stall <= rx_hold || (rx_wait > 0);
        end
    end

    task automatic send_point(point_req_t p);
        int gap;
        frame_start    <= p.fs;
        x_coord        <= p.x;
        y_coord        <= p.y;
        z_coord        <= p.z;
        ring           <= p.ring;
        point_time     <= p.pt;
        coords_invalid <= p.inv;
        in_valid       <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        predict_point_time(p);
        gap = idling ? $urandom_range(0, 5) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // leaves the block idle: input quiet, all results back, pipeline empty
    task automatic drain_and_idle();
        in_valid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] value);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_DECIMATION: cfg_interval        = int'(value[6:0]);
            REG_TS_PRESENT: cfg_use_sensor_time = value[0];
            REG_TIME_GAIN:  cfg_gain            = value;
            REG_MS_PER_DEG: cfg_ms_per_deg      = value;
            default: ;
        endcase
    endtask

    function automatic point_req_t make_point(bit fs, int xc, int yc, int zc, int r,
                                              int pt, bit inv);
        point_req_t p;
        p.fs   = fs;
        p.x    = coord_t'(xc);
        p.y    = coord_t'(yc);
        p.z    = coord_t'(zc);
        p.ring = 6'(r);
        p.pt   = 20'(pt);
        p.inv  = inv;
        return p;
    endfunction

    function automatic coord_t pick_coord();
        logic [31:0] raw;
        raw = $urandom;
        case ($urandom_range(0, 5))
            0: return coord_t'($signed(raw[11:0]));
            1:
            begin
                case (raw[1:0])
                    2'd0: return 24'sh7FFFFF;
                    2'd1: return 24'sh800000;
                    2'd2: return '0;
                    default: return '1;
                endcase
            end
            default: return coord_t'(raw[23:0]);
        endcase
    endfunction

    function automatic logic [19:0] pick_time();
        logic [31:0] raw;
        raw = $urandom;
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return 20'(raw[9:0]);
            default: return raw[19:0];
        endcase
    endfunction

    // frames of random length over a small window of rings, with some noise
    task automatic run_frames(int total);
        point_req_t p;
        int sent;
        int frame_len;
        int ring_base;
        int ring_span;
        sent = 0;
        while (sent < total)
        begin
            frame_len = $urandom_range(6, 48);
            ring_base = $urandom_range(0, 63);
            ring_span = $urandom_range(1, 6);
            for (int k = 0; k < frame_len && sent < total; k++)
            begin
                p.fs   = (k == 0) ? ($urandom_range(0, 19) != 0) : ($urandom_range(0, 39) == 0);
                p.x    = pick_coord();
                p.y    = pick_coord();
                p.z    = pick_coord();
                if ($urandom_range(0, 9) == 0)
                    p.ring = 6'($urandom);
                else
                    p.ring = 6'((ring_base + $urandom_range(0, ring_span - 1)) % 64);
                p.pt   = pick_time();
                p.inv  = ($urandom_range(0, 11) == 0);
                send_point(p);
                sent++;
            end
        end
    endtask

    task automatic test_sensor_time();
        drain_and_idle();
        write_reg(REG_TS_PRESENT, 16'd1);
        write_reg(REG_TIME_GAIN, 16'hFFFF);
        send_point(make_point(1, 8388607, -8388608, -8388608, 63, 0, 0));
        send_point(make_point(0, -8388608, 8388607, 8388607, 0, 20'hFFFFF, 0));
        send_point(make_point(0, 0, -1, 0, 21, 1, 0));
        send_point(make_point(0, 5, 6, 7, 42, 20'hFFFFF, 1));
        drain_and_idle();
        write_reg(REG_TIME_GAIN, 16'd0);
        send_point(make_point(0, 11, 22, 33, 10, 20'hFFFFF, 0));
        drain_and_idle();
        write_reg(REG_TIME_GAIN, 16'd256);
        send_point(make_point(0, -11, -22, -33, 10, 12345, 0));
    endtask

    task automatic test_azimuth();
        drain_and_idle();
        write_reg(REG_TS_PRESENT, 16'd0);
        write_reg(REG_TIME_GAIN, 16'd262);
        write_reg(REG_MS_PER_DEG, 16'd18154);
        // ring 5 reference on the +x axis, then each quadrant and the origin
        send_point(make_point(1, 1000, 0, 1, 5, 0, 0));
        send_point(make_point(0, 0, 1000, 2, 5, 0, 0));
        send_point(make_point(0, -1000, 0, 3, 5, 0, 0));
        send_point(make_point(0, 0, -1000, 4, 5, 0, 0));
        send_point(make_point(0, 0, 0, 5, 5, 0, 0));
        send_point(make_point(0, -1000, -1, 6, 5, 0, 0));
        send_point(make_point(0, 8388607, 8388607, 8388607, 5, 0, 0));
        send_point(make_point(0, -8388608, -8388608, -8388608, 5, 0, 0));
        // invalid point must not take the ring reference
        send_point(make_point(0, 100, 100, 0, 6, 0, 1));
        send_point(make_point(0, -8388608, 8388607, 0, 6, 0, 0));
        send_point(make_point(0, 8388607, -8388608, 0, 6, 0, 0));
        send_point(make_point(0, -300, 200, 0, 63, 0, 0));
        send_point(make_point(0, -300, -200, 0, 63, 0, 0));
        send_point(make_point(0, 300, -200, 0, 0, 0, 0));
        send_point(make_point(0, 300, 200, 0, 0, 0, 0));
        drain_and_idle();
        write_reg(REG_MS_PER_DEG, 16'hFFFF);
        send_point(make_point(0, 1000, -1000, 0, 5, 0, 0));
        drain_and_idle();
        write_reg(REG_MS_PER_DEG, 16'd1);
        send_point(make_point(0, 1000, 1000, 0, 5, 0, 0));
        // new frame forgets the ring reference
        send_point(make_point(1, 1000, 1000, 0, 5, 0, 0));
    endtask

    task automatic test_register_sweep();
        for (int phase = 0; phase < 10; phase++)
        begin
            drain_and_idle();
            idling = (phase % 3 != 2);
            write_reg(REG_DECIMATION, 16'(sweep_interval[phase]));
            write_reg(REG_TS_PRESENT, 16'(sweep_sensor[phase]));
            case (phase % 4)
                0: write_reg(REG_TIME_GAIN, 16'd0);
                1: write_reg(REG_TIME_GAIN, 16'hFFFF);
                2: write_reg(REG_TIME_GAIN, 16'd262);
                default: write_reg(REG_TIME_GAIN, 16'($urandom));
            endcase
            case ((phase + 1) % 4)
                0: write_reg(REG_MS_PER_DEG, 16'd1);
                1: write_reg(REG_MS_PER_DEG, 16'hFFFF);
                2: write_reg(REG_MS_PER_DEG, 16'd18154);
                default: write_reg(REG_MS_PER_DEG, 16'($urandom_range(1, 65535)));
            endcase
            run_frames(70);
        end
    endtask

    // result side held off while requests keep coming, so the input backs up
    task automatic test_output_hold();
        drain_and_idle();
        idling = 1'b0;
        write_reg(REG_DECIMATION, 16'd1);
        write_reg(REG_TS_PRESENT, 16'd1);
        hold_left <= 300;
        run_frames(25);
        drain_and_idle();
        write_reg(REG_TS_PRESENT, 16'd0);
        write_reg(REG_MS_PER_DEG, 16'd18154);
        hold_left <= 400;
        run_frames(25);
        drain_and_idle();
        idling = 1'b1;
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_write_en   = 1'b0;
        cfg_index      = REG_DECIMATION;
        cfg_data       = '0;
        in_valid       = 1'b0;
        frame_start    = 1'b0;
        x_coord        = '0;
        y_coord        = '0;
        z_coord        = '0;
        ring           = '0;
        point_time     = '0;
        coords_invalid = 1'b0;

        cfg_interval        = 1;
        cfg_use_sensor_time = 1'b0;
        cfg_gain            = 262;
        cfg_ms_per_deg      = 18154;
        foreach (ring_marked[i])
        begin
            ring_marked[i]    = 1'b0;
            ring_first_az[i]  = 0;
            ring_last_time[i] = 0;
        end
        point_phase = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_sensor_time();
        test_azimuth();
        test_register_sweep();
        test_output_hold();
        drain_and_idle();

        if (fault_count == 0 && pending_points.size() == 0)
            $display("ring_point_time_from_yaw_unit_test: done, clean");
        else
            $display("ring_point_time_from_yaw_unit_test: done, errors");
        $finish;
    end

endmodule
